>>> rtl/core/kmce_pkg.sv
// ----------------------------------------------------------------------------
// kmce_pkg
// Shared types and constants for the k-means clustering engine.
// ----------------------------------------------------------------------------
package kmce_pkg;

  localparam int unsigned DEF_MAX_POINTS   = 1024;
  localparam int unsigned DEF_MAX_CLUSTERS = 8;
  localparam int unsigned DEF_MAX_DIMS     = 8;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIM_W   = 3;
  localparam int unsigned CL_W    = 3;
  localparam int unsigned SLOTS   = 8;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned SQ_W    = 65;
  localparam int unsigned DIST_W  = SQ_W + 3;
  localparam int unsigned ITER_W  = 16;
  localparam int unsigned STEP_W  = 6;

  localparam logic [15:0] MAX_ITER_RST = 16'd300;

  localparam logic [1:0] CMD_LOAD_POINT    = 2'd0;
  localparam logic [1:0] CMD_LOAD_CENTROID = 2'd1;
  localparam logic [1:0] CMD_START         = 2'd2;
  localparam logic [1:0] CMD_UNUSED        = 2'd3;

  localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd1;
  localparam logic [1:0] REG_NUM_DIMS     = 2'd2;
  localparam logic [1:0] REG_MAX_ITER     = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         item_index;
    logic [2:0]         dim_index;
    logic signed [31:0] coord_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         cluster_index;
    logic [2:0]         coord_dim;
    logic signed [31:0] centroid_value;
    logic               empty_cluster;
    logic               converged;
    logic [15:0]        iterations_done;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [DIM_W-1:0]   dim;
    logic               last;
    logic [COORD_W-1:0] coord;
  } flow_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] score;
    logic [CL_W-1:0]   idx;
  } best_t;

  typedef struct packed {
    logic                          valid;
    logic [CL_W-1:0]               idx;
    logic [SLOTS-1:0][COORD_W-1:0] vec;
  } accum_t;

  typedef struct packed {
    logic               we;
    logic [CL_W-1:0]    idx;
    logic [DIM_W-1:0]   dim;
    logic [COORD_W-1:0] value;
  } cent_wr_t;

  typedef struct packed {
    logic [COORD_W-1:0] rd_val;
    logic               empty;
    logic               changed;
    logic               busy;
  } cell_stat_t;

endpackage

>>> rtl/core/kmce_cell.sv
// ----------------------------------------------------------------------------
// kmce_cell
// One centroid cell: distance accumulation, best-so-far compare, cluster sums
// and a serial divider for the centroid update.
// ----------------------------------------------------------------------------
module kmce_cell import kmce_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  flow_t            flow_i,
  output flow_t            flow_o,
  input  best_t            best_i,
  output best_t            best_o,
  input  accum_t           accum_i,
  input  logic             clear_i,
  input  logic             upd_start_i,
  input  logic [CL_W-1:0]  km1_i,
  input  logic [DIM_W-1:0] dm1_i,
  input  cent_wr_t         cent_wr_i,
  input  logic [DIM_W-1:0] rd_dim_i,
  output cell_stat_t       stat_o
);

  logic [COORD_W-1:0] cent_q [SLOTS];
  logic [SUM_W-1:0]   sum_q  [SLOTS];
  logic [CNT_W-1:0]   cnt_q;

  flow_t            fa_q;
  logic [SQ_W-1:0]  sq_q;
  logic [DIST_W-1:0] acc_q;
  best_t            best_q;

  logic              busy_q, ld_q, neg_q, changed_q;
  logic [DIM_W-1:0]  uj_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;

  logic               en;
  logic signed [32:0] diff;
  logic signed [65:0] prod;
  logic [DIST_W-1:0]  tot;
  logic [CNT_W:0]     rem_sh;
  logic               ge;
  logic [CNT_W-1:0]   rem_n;
  logic [SUM_W-1:0]   dvd_n;
  logic [SUM_W-1:0]   mag;
  logic [COORD_W-1:0] qv;

  assign en   = 32'(km1_i) >= CELL_IDX;
  assign diff = $signed({flow_i.coord[31], flow_i.coord}) -
                $signed({cent_q[flow_i.dim][31], cent_q[flow_i.dim]});
  assign prod = diff * diff;
  assign tot  = ((fa_q.dim == '0) ? '0 : acc_q) + DIST_W'(sq_q);

  assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, cnt_q};
  assign rem_n  = ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : CNT_W'(rem_sh);
  assign dvd_n  = {dvd_q[SUM_W-2:0], ge};
  assign mag    = sum_q[uj_q][SUM_W-1] ? (~sum_q[uj_q] + 1'b1) : sum_q[uj_q];
  assign qv     = neg_q ? (~dvd_n[COORD_W-1:0] + 1'b1) : dvd_n[COORD_W-1:0];

  assign flow_o = fa_q;
  assign best_o = best_q;
  assign stat_o = '{rd_val: cent_q[rd_dim_i], empty: (cnt_q == '0),
                    changed: changed_q, busy: busy_q};

  // distance pipeline and best compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q         <= '0;
      best_q.valid <= 1'b0;
    end else begin
      fa_q <= flow_i;
      if (fa_q.valid && fa_q.last) begin
        if (en && (!best_i.valid || tot < best_i.score)) begin
          best_q <= '{valid: 1'b1, score: tot, idx: CL_W'(CELL_IDX)};
        end else begin
          best_q <= best_i;
        end
      end else begin
        best_q.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= prod[SQ_W-1:0];
    if (fa_q.valid) begin
      acc_q <= tot;
    end
  end

  // sums, counts, centroid and serial update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      ld_q      <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      if (clear_i) begin
        cnt_q <= '0;
      end else if (accum_i.valid && (32'(accum_i.idx) == CELL_IDX)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (upd_start_i) begin
        changed_q <= 1'b0;
        busy_q    <= en && (cnt_q != '0);
        ld_q      <= 1'b1;
        uj_q      <= '0;
      end else if (busy_q) begin
        if (ld_q) begin
          ld_q   <= 1'b0;
          dvd_q  <= mag;
          neg_q  <= sum_q[uj_q][SUM_W-1];
          rem_q  <= '0;
          step_q <= '0;
        end else begin
          dvd_q  <= dvd_n;
          rem_q  <= rem_n;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SUM_W - 1)) begin
            if (qv != cent_q[uj_q]) begin
              changed_q <= 1'b1;
            end
            if (uj_q == dm1_i) begin
              busy_q <= 1'b0;
            end else begin
              uj_q <= uj_q + 1'b1;
              ld_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < SLOTS; j++) begin
      if (clear_i) begin
        sum_q[j] <= '0;
      end else if (accum_i.valid && (32'(accum_i.idx) == CELL_IDX)) begin
        sum_q[j] <= sum_q[j] + {{(SUM_W-COORD_W){accum_i.vec[j][COORD_W-1]}}, accum_i.vec[j]};
      end
    end
    if (cent_wr_i.we && (32'(cent_wr_i.idx) == CELL_IDX)) begin
      cent_q[cent_wr_i.dim] <= cent_wr_i.value;
    end else if (busy_q && !ld_q && (step_q == STEP_W'(SUM_W - 1))) begin
      cent_q[uj_q] <= qv;
    end
  end

endmodule

>>> rtl/core/kmeans_clustering_engine_top.sv
// ----------------------------------------------------------------------------
// kmeans_clustering_engine_top
// Lloyd k-means engine built as a chain of centroid cells.
// ----------------------------------------------------------------------------
// Load transfers: one per cycle while idle, no result.
// Start: per pass the point coordinates stream through the cell chain (one
//   coordinate per cycle from the point memory read port), then the cells run
//   a serial division per dimension; then k*d result items.
// No new input is taken while a start is in progress.
// Reset returns the control FSM to idle and sets the config registers to their
//   defaults; point and centroid stores are undefined until loaded.
// ----------------------------------------------------------------------------
module kmeans_clustering_engine_top import kmce_pkg::*; #(
  parameter int unsigned MAX_POINTS   = DEF_MAX_POINTS,
  parameter int unsigned MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int unsigned MAX_DIMS     = DEF_MAX_DIMS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW        = $clog2(MAX_POINTS);
  localparam int unsigned MEM_DEPTH = MAX_POINTS * SLOTS;
  localparam int unsigned DRAIN     = MAX_CLUSTERS + 4;
  localparam int unsigned NP_RST    = (MAX_POINTS > 2047) ? 2047 : MAX_POINTS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FEED, ST_DRAIN, ST_UPD_GO, ST_UPD_WAIT, ST_OUT, ST_FLUSH
  } state_e;

  state_e state_q;

  logic [10:0] num_points_q;
  logic [3:0]  num_clusters_q, num_dims_q;
  logic [15:0] max_iter_q;

  logic [PW-1:0]    nm1_q, p_q;
  logic [CL_W-1:0]  km1_q, oc_q;
  logic [DIM_W-1:0] dm1_q, fj_q, oj_q;
  logic [ITER_W-1:0] iter_q;
  logic              ran_q, conv_q, clr_q;
  logic [3:0]        drain_q;

  logic               fv_q, flast_q;
  logic [DIM_W-1:0]   fdim_q;
  logic [COORD_W-1:0] rdata_q;
  logic [COORD_W-1:0] pmem [MEM_DEPTH];

  logic [COORD_W-1:0] buf_q [SLOTS];

  logic      out_valid_q;
  out_item_t out_q;

  flow_t      flow [MAX_CLUSTERS+1];
  best_t      best [MAX_CLUSTERS+1];
  cell_stat_t stat [MAX_CLUSTERS];
  accum_t     accum;
  cent_wr_t   cent_wr;

  logic [MAX_CLUSTERS-1:0] busy_v, chg_v;
  logic       in_xfer, cfg_wr, pt_we, rd_en, upd_go, slot_free;
  logic [PW+DIM_W-1:0] waddr, raddr;
  logic [CNT_W-1:0]    n_cl;
  logic [3:0]          k_cl, d_cl;

  assign pready     = 1'b1;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    case (paddr[3:2])
      REG_NUM_POINTS:   prdata = 32'(num_points_q);
      REG_NUM_CLUSTERS: prdata = 32'(num_clusters_q);
      REG_NUM_DIMS:     prdata = 32'(num_dims_q);
      REG_MAX_ITER:     prdata = 32'(max_iter_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= 11'(NP_RST);
      num_clusters_q <= 4'(MAX_CLUSTERS);
      num_dims_q     <= 4'(MAX_DIMS);
      max_iter_q     <= MAX_ITER_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NUM_POINTS:   num_points_q   <= pwdata[10:0];
        REG_NUM_CLUSTERS: num_clusters_q <= pwdata[3:0];
        REG_NUM_DIMS:     num_dims_q     <= pwdata[3:0];
        REG_MAX_ITER:     max_iter_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // clamped counts
  assign n_cl = (num_points_q == '0) ? CNT_W'(1) :
                (32'(num_points_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : num_points_q;
  assign k_cl = (num_clusters_q == '0) ? 4'd1 :
                (32'(num_clusters_q) > MAX_CLUSTERS) ? 4'(MAX_CLUSTERS) : num_clusters_q;
  assign d_cl = (num_dims_q == '0) ? 4'd1 :
                (32'(num_dims_q) > MAX_DIMS) ? 4'(MAX_DIMS) : num_dims_q;

  // point memory
  assign pt_we = in_xfer && (in_data_i.cmd == CMD_LOAD_POINT) &&
                 (32'(in_data_i.item_index) < MAX_POINTS) &&
                 (32'(in_data_i.dim_index) < MAX_DIMS);
  assign waddr = {PW'(in_data_i.item_index), in_data_i.dim_index};
  assign rd_en = (state_q == ST_FEED);
  assign raddr = {p_q, fj_q};

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pmem[waddr] <= in_data_i.coord_value;
    end
    if (rd_en) begin
      rdata_q <= pmem[raddr];
    end
  end

  assign cent_wr = '{
    we:    in_xfer && (in_data_i.cmd == CMD_LOAD_CENTROID) &&
           (32'(in_data_i.item_index) < MAX_CLUSTERS) &&
           (32'(in_data_i.dim_index) < MAX_DIMS),
    idx:   in_data_i.item_index[CL_W-1:0],
    dim:   in_data_i.dim_index,
    value: in_data_i.coord_value
  };

  // cell chain
  assign flow[0] = '{valid: fv_q, dim: fdim_q, last: flast_q, coord: rdata_q};
  assign best[0] = '0;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    kmce_cell #(.CELL_IDX(c)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .flow_i      (flow[c]),
      .flow_o      (flow[c+1]),
      .best_i      (best[c]),
      .best_o      (best[c+1]),
      .accum_i     (accum),
      .clear_i     (clr_q),
      .upd_start_i (upd_go),
      .km1_i       (km1_q),
      .dm1_i       (dm1_q),
      .cent_wr_i   (cent_wr),
      .rd_dim_i    (oj_q),
      .stat_o      (stat[c])
    );
    assign busy_v[c] = stat[c].busy;
    assign chg_v[c]  = stat[c].changed;
  end

  // tail buffer: whole point vector lines up with its best cluster
  always_ff @(posedge clk_i) begin
    if (flow[MAX_CLUSTERS].valid) begin
      buf_q[flow[MAX_CLUSTERS].dim] <= flow[MAX_CLUSTERS].coord;
    end
  end

  always_comb begin
    accum.valid = best[MAX_CLUSTERS].valid;
    accum.idx   = best[MAX_CLUSTERS].idx;
    for (int j = 0; j < SLOTS; j++) begin
      accum.vec[j] = buf_q[j];
    end
  end

  assign upd_go = (state_q == ST_UPD_GO);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fv_q        <= 1'b0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      ran_q       <= 1'b0;
      conv_q      <= 1'b0;
    end else begin
      fv_q  <= 1'b0;
      clr_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_data_i.cmd == CMD_START)) begin
            nm1_q  <= PW'(n_cl - 1'b1);
            km1_q  <= CL_W'(k_cl - 1'b1);
            dm1_q  <= DIM_W'(d_cl - 1'b1);
            iter_q <= '0;
            ran_q  <= 1'b0;
            conv_q <= 1'b0;
            p_q    <= '0;
            fj_q   <= '0;
            oc_q   <= '0;
            oj_q   <= '0;
            if (max_iter_q == '0) begin
              state_q <= ST_OUT;
            end else begin
              clr_q   <= 1'b1;
              state_q <= ST_FEED;
            end
          end
        end
        ST_FEED: begin
          fv_q    <= 1'b1;
          fdim_q  <= fj_q;
          flast_q <= (fj_q == dm1_q);
          if (fj_q == dm1_q) begin
            fj_q <= '0;
            p_q  <= p_q + 1'b1;
            if (p_q == nm1_q) begin
              drain_q <= '0;
              state_q <= ST_DRAIN;
            end
          end else begin
            fj_q <= fj_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == 4'(DRAIN)) begin
            state_q <= ST_UPD_GO;
          end
        end
        ST_UPD_GO: begin
          state_q <= ST_UPD_WAIT;
        end
        ST_UPD_WAIT: begin
          if (busy_v == '0) begin
            ran_q <= 1'b1;
            p_q   <= '0;
            if (chg_v == '0) begin
              conv_q  <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              iter_q <= iter_q + 1'b1;
              if ((iter_q + 1'b1) < max_iter_q) begin
                clr_q   <= 1'b1;
                state_q <= ST_FEED;
              end else begin
                state_q <= ST_OUT;
              end
            end
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{
              cluster_index:   oc_q,
              coord_dim:       oj_q,
              centroid_value:  stat[oc_q].rd_val,
              empty_cluster:   ran_q && stat[oc_q].empty,
              converged:       conv_q,
              iterations_done: iter_q,
              last:            (oc_q == km1_q) && (oj_q == dm1_q)
            };
            if (oj_q == dm1_q) begin
              oj_q <= '0;
              oc_q <= oc_q + 1'b1;
              if (oc_q == km1_q) begin
                state_q <= ST_FLUSH;
              end
            end else begin
              oj_q <= oj_q + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
